// ===== sv/lca_pkg.sv =====
// ============================================================================
// lca_pkg
// Shared types and constants for the binary-lifting LCA engine.
// ============================================================================
package lca_pkg;

    localparam int FIELD_W = 10;
    localparam int DEPTH_W = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        OP_CLR, OP_IDLE, OP_SAN_RD, OP_SAN_WR, OP_DEP_RD, OP_DEP_PAR, OP_DEP_WR,
        OP_LVL_RD1, OP_LVL_RD2, OP_LVL_WR, OP_Q_RD0, OP_Q_RD1, OP_Q_SWAP,
        OP_UP_RD, OP_UP_DRD, OP_UP_CMP, OP_EQ, OP_DN_RDA, OP_DN_RDB, OP_DN_CMP,
        OP_PAR_RD, OP_PAR_W, OP_W_RD, OP_CALC, OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic idx_last;
        logic idx_past;
        logic k_zero;
        logic k_top;
        logic changed;
        logic err;
        logic uv_eq;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/lca_datapath.sv =====
// ============================================================================
// lca_datapath
// Jump and depth memories, index counters and query registers.
// ============================================================================
module lca_datapath #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lca_pkg::t_ctrl                 i_ctrl,
    output lca_pkg::t_stat                 o_stat,
    input  lca_pkg::t_cmd                  i_cmd,
    input  logic [lca_pkg::FIELD_W-1:0]    i_first,
    input  logic [lca_pkg::FIELD_W-1:0]    i_second,
    input  logic                           i_cfg_valid,
    input  logic [lca_pkg::FIELD_W-1:0]    i_cfg_data,
    input  logic                           i_m_ready,
    output logic                           o_m_valid,
    output logic [lca_pkg::DEPTH_W-1:0]    o_node_depth,
    output logic [lca_pkg::DEPTH_W-1:0]    o_distance_up,
    output logic                           o_error
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int KW = $clog2(LOG_LEVELS);
    localparam int CW = ((NW > lca_pkg::FIELD_W) ? NW : lca_pkg::FIELD_W) + 1;
    localparam int JD = LOG_LEVELS * MAX_NODES;
    localparam int AW = $clog2(JD);
    localparam int DW = lca_pkg::DEPTH_W;
    localparam logic [CW-1:0] NMAX  = CW'(MAX_NODES);
    localparam logic [CW-1:0] NLAST = CW'(MAX_NODES - 1);
    localparam logic [KW-1:0] KTOP  = KW'(LOG_LEVELS - 1);

    logic [NW-1:0] r_jmem [JD];
    logic [DW-1:0] r_dmem [MAX_NODES];
    logic [NW-1:0] r_jrd;
    logic [DW-1:0] r_drd;

    logic [lca_pkg::FIELD_W-1:0] r_count;
    logic [NW:0]   r_idx;
    logic [KW-1:0] r_k;
    logic          r_changed;
    logic          r_err;
    logic          r_ovalid;
    logic [NW-1:0] r_u, r_v, r_a, r_par;
    logic [DW-1:0] r_du, r_dv, r_dvo, r_dfirst, r_dist;
    logic [DW-1:0] r_odepth, r_odist;
    logic          r_oerr;

    logic          j_we, d_we;
    logic [AW-1:0] j_waddr, j_raddr;
    logic [NW-1:0] j_wdata, d_waddr, d_raddr;
    logic [DW-1:0] d_wdata;

    logic [CW-1:0] eff, first_w, second_w, idx_w;
    logic          first_ok, second_ok, dep_upd, out_free;
    logic [NW-1:0] idx_n, san;
    logic [KW-1:0] km1;

    function automatic logic [AW-1:0] ja(input logic [KW-1:0] k, input logic [NW-1:0] u);
        ja = AW'(AW'(k) * AW'(MAX_NODES) + AW'(u));
    endfunction

    assign eff       = (CW'(r_count) > NLAST) ? NLAST : CW'(r_count);
    assign first_w   = CW'(i_first);
    assign second_w  = CW'(i_second);
    assign idx_w     = CW'(r_idx);
    assign first_ok  = (first_w >= CW'(1)) && (first_w <= eff);
    assign second_ok = (second_w >= CW'(1)) && (second_w <= eff);
    assign idx_n     = r_idx[NW-1:0];
    assign km1       = r_k - KW'(1);
    assign san       = ((idx_w <= CW'(1)) || (idx_w > eff) || (CW'(r_jrd) > eff))
                       ? '0 : r_jrd;
    assign dep_upd   = (r_du == '0) && (r_par != '0) && (r_drd != '0);
    assign out_free  = !r_ovalid || i_m_ready;

    assign o_stat.idx_last = (idx_w == NLAST);
    assign o_stat.idx_past = (idx_w > eff);
    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.k_top    = (r_k == KTOP);
    assign o_stat.changed  = r_changed;
    assign o_stat.err      = r_err;
    assign o_stat.uv_eq    = (r_u == r_v);
    assign o_stat.out_free = out_free;

    always_comb begin
        j_we    = 1'b0;
        j_waddr = '0;
        j_wdata = '0;
        j_raddr = '0;
        d_we    = 1'b0;
        d_waddr = '0;
        d_wdata = '0;
        d_raddr = '0;
        case (i_ctrl.op)
            lca_pkg::OP_CLR: begin
                j_we    = 1'b1;
                j_waddr = ja('0, idx_n);
            end
            lca_pkg::OP_IDLE: begin
                if (i_ctrl.accept && i_cmd == lca_pkg::CMD_LOAD && first_ok) begin
                    j_we    = 1'b1;
                    j_waddr = ja('0, NW'(i_first));
                    j_wdata = (second_w < NMAX) ? NW'(i_second) : '0;
                end
            end
            lca_pkg::OP_SAN_RD: j_raddr = ja('0, idx_n);
            lca_pkg::OP_SAN_WR: begin
                j_we    = 1'b1;
                j_waddr = ja('0, idx_n);
                j_wdata = san;
                d_we    = 1'b1;
                d_waddr = idx_n;
                d_wdata = (idx_w == CW'(1) && eff != '0) ? DW'(1) : '0;
            end
            lca_pkg::OP_DEP_RD: begin
                j_raddr = ja('0, idx_n);
                d_raddr = idx_n;
            end
            lca_pkg::OP_DEP_PAR: d_raddr = r_jrd;
            lca_pkg::OP_DEP_WR: begin
                d_we    = dep_upd;
                d_waddr = idx_n;
                d_wdata = r_drd + DW'(1);
            end
            lca_pkg::OP_LVL_RD1: j_raddr = ja(km1, idx_n);
            lca_pkg::OP_LVL_RD2: j_raddr = ja(km1, r_jrd);
            lca_pkg::OP_LVL_WR: begin
                j_we    = 1'b1;
                j_waddr = ja(r_k, idx_n);
                j_wdata = r_jrd;
            end
            lca_pkg::OP_Q_RD0:   d_raddr = r_u;
            lca_pkg::OP_Q_RD1:   d_raddr = r_v;
            lca_pkg::OP_UP_RD:   j_raddr = ja(r_k, r_u);
            lca_pkg::OP_UP_DRD:  d_raddr = r_jrd;
            lca_pkg::OP_DN_RDA:  j_raddr = ja(r_k, r_u);
            lca_pkg::OP_DN_RDB:  j_raddr = ja(r_k, r_v);
            lca_pkg::OP_PAR_RD:  j_raddr = ja('0, r_u);
            lca_pkg::OP_W_RD:    d_raddr = r_u;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (j_we) begin
            r_jmem[j_waddr] <= j_wdata;
        end
        r_jrd <= r_jmem[j_raddr];
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        r_drd <= r_dmem[d_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= lca_pkg::FIELD_W'(1);
            r_idx     <= '0;
            r_k       <= '0;
            r_changed <= 1'b0;
            r_err     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (i_ctrl.op == lca_pkg::OP_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_ctrl.op)
                lca_pkg::OP_CLR: r_idx <= r_idx + 1'b1;
                lca_pkg::OP_IDLE: begin
                    if (i_ctrl.accept) begin
                        r_idx <= '0;
                        r_err <= !(first_ok && second_ok);
                    end
                end
                lca_pkg::OP_SAN_WR: begin
                    if (o_stat.idx_last) begin
                        r_idx     <= (NW+1)'(2);
                        r_changed <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                lca_pkg::OP_DEP_RD: begin
                    if (o_stat.idx_past) begin
                        if (r_changed) begin
                            r_idx     <= (NW+1)'(2);
                            r_changed <= 1'b0;
                        end else begin
                            r_idx <= '0;
                            r_k   <= KW'(1);
                        end
                    end
                end
                lca_pkg::OP_DEP_WR: begin
                    if (dep_upd) begin
                        r_changed <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                lca_pkg::OP_LVL_WR: begin
                    if (o_stat.idx_last) begin
                        r_idx <= '0;
                        r_k   <= r_k + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                lca_pkg::OP_Q_SWAP: r_k <= KTOP;
                lca_pkg::OP_UP_CMP: begin
                    if (r_k != '0) begin
                        r_k <= km1;
                    end
                end
                lca_pkg::OP_EQ: r_k <= KTOP;
                lca_pkg::OP_DN_CMP: begin
                    if (r_k != '0) begin
                        r_k <= km1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            lca_pkg::OP_IDLE: begin
                if (i_ctrl.accept) begin
                    r_u <= NW'(i_first);
                    r_v <= NW'(i_second);
                end
            end
            lca_pkg::OP_DEP_PAR: begin
                r_par <= r_jrd;
                r_du  <= r_drd;
            end
            lca_pkg::OP_Q_RD1: r_du <= r_drd;
            lca_pkg::OP_Q_SWAP: begin
                r_dfirst <= r_du;
                r_dvo    <= r_drd;
                if (r_du < r_drd) begin
                    r_u  <= r_v;
                    r_v  <= r_u;
                    r_dv <= r_du;
                end else begin
                    r_dv <= r_drd;
                end
            end
            lca_pkg::OP_UP_DRD: r_a <= r_jrd;
            lca_pkg::OP_UP_CMP: begin
                if (r_drd >= r_dv) begin
                    r_u <= r_a;
                end
            end
            lca_pkg::OP_DN_RDB: r_a <= r_jrd;
            lca_pkg::OP_DN_CMP: begin
                if (r_a != r_jrd) begin
                    r_u <= r_a;
                    r_v <= r_jrd;
                end
            end
            lca_pkg::OP_PAR_W: r_u <= r_jrd;
            lca_pkg::OP_CALC: r_dist <= (r_dvo >= r_drd) ? (r_dvo - r_drd) : '0;
            lca_pkg::OP_DONE: begin
                if (out_free) begin
                    r_odepth <= r_err ? '0 : r_dfirst;
                    r_odist  <= r_err ? '0 : r_dist;
                    r_oerr   <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_m_valid     = r_ovalid;
    assign o_node_depth  = r_odepth;
    assign o_distance_up = r_odist;
    assign o_error       = r_oerr;

endmodule

// ===== sv/lca_ctrl.sv =====
// ============================================================================
// lca_ctrl
// Sequencer for clear, load, build and query steps.
// ============================================================================
module lca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lca_pkg::t_cmd  i_cmd,
    input  lca_pkg::t_stat i_stat,
    output logic           o_ready,
    output lca_pkg::t_ctrl o_ctrl
);

    typedef enum logic [24:0] {
        S_CLR     = 25'h0000001,
        S_IDLE    = 25'h0000002,
        S_SAN_RD  = 25'h0000004,
        S_SAN_WR  = 25'h0000008,
        S_DEP_RD  = 25'h0000010,
        S_DEP_PAR = 25'h0000020,
        S_DEP_WR  = 25'h0000040,
        S_LVL_RD1 = 25'h0000080,
        S_LVL_RD2 = 25'h0000100,
        S_LVL_WR  = 25'h0000200,
        S_Q_RD0   = 25'h0000400,
        S_Q_RD1   = 25'h0000800,
        S_Q_SWAP  = 25'h0001000,
        S_UP_RD   = 25'h0002000,
        S_UP_DRD  = 25'h0004000,
        S_UP_CMP  = 25'h0008000,
        S_EQ      = 25'h0010000,
        S_DN_RDA  = 25'h0020000,
        S_DN_RDB  = 25'h0040000,
        S_DN_CMP  = 25'h0080000,
        S_PAR_RD  = 25'h0100000,
        S_PAR_W   = 25'h0200000,
        S_W_RD    = 25'h0400000,
        S_CALC    = 25'h0800000,
        S_DONE    = 25'h1000000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_ctrl.op     = lca_pkg::OP_IDLE;
        o_ctrl.accept = 1'b0;
        case (r_state)
            S_CLR: begin
                o_ctrl.op = lca_pkg::OP_CLR;
                if (i_stat.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ctrl.op     = lca_pkg::OP_IDLE;
                o_ctrl.accept = i_valid;
                if (i_valid) begin
                    if (i_cmd == lca_pkg::CMD_BUILD) n_state = S_SAN_RD;
                    if (i_cmd == lca_pkg::CMD_QUERY) n_state = S_Q_RD0;
                end
            end
            S_SAN_RD: begin
                o_ctrl.op = lca_pkg::OP_SAN_RD;
                n_state   = S_SAN_WR;
            end
            S_SAN_WR: begin
                o_ctrl.op = lca_pkg::OP_SAN_WR;
                n_state   = i_stat.idx_last ? S_DEP_RD : S_SAN_RD;
            end
            S_DEP_RD: begin
                o_ctrl.op = lca_pkg::OP_DEP_RD;
                if (i_stat.idx_past) begin
                    n_state = i_stat.changed ? S_DEP_RD : S_LVL_RD1;
                end else begin
                    n_state = S_DEP_PAR;
                end
            end
            S_DEP_PAR: begin
                o_ctrl.op = lca_pkg::OP_DEP_PAR;
                n_state   = S_DEP_WR;
            end
            S_DEP_WR: begin
                o_ctrl.op = lca_pkg::OP_DEP_WR;
                n_state   = S_DEP_RD;
            end
            S_LVL_RD1: begin
                o_ctrl.op = lca_pkg::OP_LVL_RD1;
                n_state   = S_LVL_RD2;
            end
            S_LVL_RD2: begin
                o_ctrl.op = lca_pkg::OP_LVL_RD2;
                n_state   = S_LVL_WR;
            end
            S_LVL_WR: begin
                o_ctrl.op = lca_pkg::OP_LVL_WR;
                n_state   = (i_stat.idx_last && i_stat.k_top) ? S_IDLE : S_LVL_RD1;
            end
            S_Q_RD0: begin
                o_ctrl.op = lca_pkg::OP_Q_RD0;
                n_state   = i_stat.err ? S_DONE : S_Q_RD1;
            end
            S_Q_RD1: begin
                o_ctrl.op = lca_pkg::OP_Q_RD1;
                n_state   = S_Q_SWAP;
            end
            S_Q_SWAP: begin
                o_ctrl.op = lca_pkg::OP_Q_SWAP;
                n_state   = S_UP_RD;
            end
            S_UP_RD: begin
                o_ctrl.op = lca_pkg::OP_UP_RD;
                n_state   = S_UP_DRD;
            end
            S_UP_DRD: begin
                o_ctrl.op = lca_pkg::OP_UP_DRD;
                n_state   = S_UP_CMP;
            end
            S_UP_CMP: begin
                o_ctrl.op = lca_pkg::OP_UP_CMP;
                n_state   = i_stat.k_zero ? S_EQ : S_UP_RD;
            end
            S_EQ: begin
                o_ctrl.op = lca_pkg::OP_EQ;
                n_state   = i_stat.uv_eq ? S_W_RD : S_DN_RDA;
            end
            S_DN_RDA: begin
                o_ctrl.op = lca_pkg::OP_DN_RDA;
                n_state   = S_DN_RDB;
            end
            S_DN_RDB: begin
                o_ctrl.op = lca_pkg::OP_DN_RDB;
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_ctrl.op = lca_pkg::OP_DN_CMP;
                n_state   = i_stat.k_zero ? S_PAR_RD : S_DN_RDA;
            end
            S_PAR_RD: begin
                o_ctrl.op = lca_pkg::OP_PAR_RD;
                n_state   = S_PAR_W;
            end
            S_PAR_W: begin
                o_ctrl.op = lca_pkg::OP_PAR_W;
                n_state   = S_W_RD;
            end
            S_W_RD: begin
                o_ctrl.op = lca_pkg::OP_W_RD;
                n_state   = S_CALC;
            end
            S_CALC: begin
                o_ctrl.op = lca_pkg::OP_CALC;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_ctrl.op = lca_pkg::OP_DONE;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/tree_lca_binary_lifting_core.sv =====
// ============================================================================
// tree_lca_binary_lifting_core
// Rooted-tree lowest common ancestor engine with binary-lifting jump table.
// ============================================================================
// After reset the block clears level 0 of the jump table with s_axis_tready
// low. A load is written while idle. A build sanitises the level-0 parents,
// repeats depth passes until no depth changes and fills the higher levels,
// each step bound by the single read port of each memory. A query makes two
// lifting walks, three memory steps per level; an index outside 1..node_count
// (capped at MAX_NODES-1) gives an error result without the walks.
// A finished result waits in the output register while the next item is taken.
module tree_lca_binary_lifting_core #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // command[1:0], first_node[11:2], second_node[21:12]
    input  logic [lca_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // node_depth[9:0], distance_up[19:10]
    output logic [lca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // error[0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lca_pkg::FIELD_W-1:0]       i_cfg_data
);

    lca_pkg::t_ctrl ctrl;
    lca_pkg::t_stat stat;
    lca_pkg::t_cmd  cmd;
    logic [lca_pkg::DEPTH_W-1:0] node_depth, distance_up;
    logic error;

    assign cmd         = lca_pkg::t_cmd'(s_axis_tdata[1:0]);
    assign o_cfg_ready = 1'b1;

    lca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (cmd),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_ctrl  (ctrl)
    );

    lca_datapath #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_cmd         (cmd),
        .i_first       (s_axis_tdata[11:2]),
        .i_second      (s_axis_tdata[21:12]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_node_depth  (node_depth),
        .o_distance_up (distance_up),
        .o_error       (error)
    );

    assign m_axis_tdata = {4'b0, distance_up, node_depth};
    assign m_axis_tuser = error;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero payload");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken during table clear");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == lca_pkg::CMD_QUERY)
        |=> !s_axis_tready)
        else $error("query did not hold off input");

endmodule
